### src/spm_pkg.sv
// Shared types and constants for the Sv32 page mapper.
// No dependencies; every other file of the block imports this package.
package spm_pkg;

   // Request beat: one mapping to install.
   typedef struct packed {
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [7:0]  perm_flags;
   } req_type;

   // Response beat: one page-table-entry write, or an error.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] write_addr;
      logic [31:0] write_data;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   localparam logic [1:0] KIND_NEW_TABLE = 2'd0;
   localparam logic [1:0] KIND_LEAF      = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_VIRT  = 2'd1;
   localparam logic [1:0] STATUS_BAD_PHYS  = 2'd2;
   localparam logic [1:0] STATUS_NO_PAGES  = 2'd3;

   localparam logic [1:0] CSR_ROOT_PAGE  = 2'd0;
   localparam logic [1:0] CSR_POOL_START = 2'd1;
   localparam logic [1:0] CSR_POOL_END   = 2'd2;

   localparam int CSR_DATA_W  = 21;
   localparam int ROOT_ENTRIES = 1024;
   localparam int VPN_W       = 10;
   localparam int PPN_W       = 20;

   // Datapath operation selected by the current control word.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_EMIT_L1,
      OP_EMIT_LEAF,
      OP_EMIT_ERR
   } op_type;

   // Jump condition of the current control word.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_CLR_BUSY,
      COND_NO_REQ,
      COND_CLASS
   } cond_type;

   // Outcome of checking a request against the root mirror; also a jump offset.
   typedef enum logic [1:0] {
      CLASS_NEW_TABLE = 2'd0,
      CLASS_MAPPED    = 2'd1,
      CLASS_ERROR     = 2'd2
   } class_type;

   typedef struct packed {
      op_type     op;
      cond_type   cond;
      logic [2:0] target;
   } uop_type;

   // Datapath status seen by the sequencer.
   typedef struct packed {
      logic      clr_busy;
      logic      out_free;
      class_type cls;
   } dp_stat_type;

endpackage

### src/spm_sequencer.sv
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on spm_pkg.
module spm_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  spm_pkg::dp_stat_type stat,
   output spm_pkg::uop_type     uop
);
   import spm_pkg::*;

   localparam logic [2:0] STEP_CLEAR = 3'd0;
   localparam logic [2:0] STEP_WAIT  = 3'd1;
   localparam logic [2:0] STEP_CHECK = 3'd2;
   localparam logic [2:0] STEP_L1    = 3'd3;
   localparam logic [2:0] STEP_LEAF  = 3'd4;
   localparam logic [2:0] STEP_ERR   = 3'd5;

   // The check step dispatches to STEP_L1 plus the request class, so the
   // three outcome steps must stay in class order.
   function automatic uop_type rom_word(input logic [2:0] step);
      uop_type w;
      w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (step)
         STEP_CLEAR: w = '{op: OP_CLEAR,     cond: COND_CLR_BUSY, target: STEP_CLEAR};
         STEP_WAIT:  w = '{op: OP_ACCEPT,    cond: COND_NO_REQ,   target: STEP_WAIT};
         STEP_CHECK: w = '{op: OP_NONE,      cond: COND_CLASS,    target: STEP_L1};
         STEP_L1:    w = '{op: OP_EMIT_L1,   cond: COND_NEVER,    target: STEP_LEAF};
         STEP_LEAF:  w = '{op: OP_EMIT_LEAF, cond: COND_ALWAYS,   target: STEP_WAIT};
         STEP_ERR:   w = '{op: OP_EMIT_ERR,  cond: COND_ALWAYS,   target: STEP_WAIT};
         default:    w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: STEP_WAIT};
      endcase
      return w;
   endfunction

   logic [2:0] step_ff;
   logic [2:0] step_in;
   logic       taken;
   logic       hold;

   assign uop = rom_word(step_ff);

   always_comb begin
      case (uop.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_CLR_BUSY: taken = stat.clr_busy;
         COND_NO_REQ:   taken = !req_valid;
         COND_CLASS:    taken = 1'b1;
         default:       taken = 1'b1;
      endcase
   end

   // An emit step waits in place until the response register can take a beat.
   assign hold = (uop.op == OP_EMIT_L1 || uop.op == OP_EMIT_LEAF ||
                  uop.op == OP_EMIT_ERR) && !stat.out_free;

   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (uop.cond == COND_CLASS) begin
         step_in = uop.target + 3'(stat.cls);
      end else if (taken) begin
         step_in = uop.target;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### src/spm_datapath.sv
// Datapath: configuration registers, root mirror memory, request latch,
// free-page pointer and response register. Depends on spm_pkg.
module spm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  spm_pkg::uop_type              uop,
   output spm_pkg::dp_stat_type          stat,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  spm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output spm_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [spm_pkg::CSR_DATA_W-1:0] csr_data
);
   import spm_pkg::*;

   logic [PPN_W-1:0]   root_page_ff;
   logic [PPN_W:0]     pool_end_ff;
   logic [PPN_W:0]     next_free_ff;
   logic [VPN_W:0]     clr_cnt_ff;
   req_type            req_ff;
   logic [PPN_W:0]     mirror_rd_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [PPN_W:0]     mirror [ROOT_ENTRIES];

   logic               accept;
   logic               clr_busy;
   logic               out_free;
   logic               emit;
   logic               fire;
   logic               l1_fire;
   logic               mem_we;
   logic [VPN_W-1:0]   mem_waddr;
   logic [PPN_W:0]     mem_wdata;
   class_type          cls;
   logic [1:0]         err_code;
   logic [VPN_W-1:0]   vpn1;
   logic [VPN_W-1:0]   vpn0;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && (uop.op == OP_ACCEPT);
   assign req_stall = (uop.op != OP_ACCEPT);
   assign clr_busy  = !clr_cnt_ff[VPN_W];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (uop.op == OP_EMIT_L1) || (uop.op == OP_EMIT_LEAF) ||
                      (uop.op == OP_EMIT_ERR);
   assign fire      = emit && out_free;
   assign l1_fire   = fire && (uop.op == OP_EMIT_L1);
   assign vpn1      = req_ff.virt_addr[31:22];
   assign vpn0      = req_ff.virt_addr[21:12];

   // Request classification; virtual alignment takes priority over physical.
   always_comb begin
      cls      = CLASS_NEW_TABLE;
      err_code = STATUS_OK;
      if (req_ff.virt_addr[11:0] != 12'd0) begin
         cls      = CLASS_ERROR;
         err_code = STATUS_BAD_VIRT;
      end else if (req_ff.phys_addr[11:0] != 12'd0) begin
         cls      = CLASS_ERROR;
         err_code = STATUS_BAD_PHYS;
      end else if (mirror_rd_ff[PPN_W]) begin
         cls      = CLASS_MAPPED;
      end else if (next_free_ff[PPN_W] || (next_free_ff >= pool_end_ff)) begin
         cls      = CLASS_ERROR;
         err_code = STATUS_NO_PAGES;
      end
   end

   assign stat = '{clr_busy: clr_busy, out_free: out_free, cls: cls};

   always_comb begin
      rsp_in = '{kind: KIND_ERROR, write_addr: 32'd0, write_data: 32'd0,
                 status: err_code, last: 1'b1};
      case (uop.op)
         OP_EMIT_L1: begin
            rsp_in.kind       = KIND_NEW_TABLE;
            rsp_in.write_addr = {root_page_ff, vpn1, 2'b00};
            rsp_in.write_data = {2'b00, next_free_ff[PPN_W-1:0], 10'h001};
            rsp_in.status     = STATUS_OK;
            rsp_in.last       = 1'b0;
         end
         OP_EMIT_LEAF: begin
            rsp_in.kind       = KIND_LEAF;
            rsp_in.write_addr = {mirror_rd_ff[PPN_W-1:0], vpn0, 2'b00};
            rsp_in.write_data = {2'b00, req_ff.phys_addr[31:12], 10'd0} |
                                {24'd0, req_ff.perm_flags} | 32'd1;
            rsp_in.status     = STATUS_OK;
            rsp_in.last       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // One write port shared by the clearing sweep and new-table allocation.
   assign mem_we    = (uop.op == OP_CLEAR && clr_busy) || l1_fire;
   assign mem_waddr = l1_fire ? vpn1 : clr_cnt_ff[VPN_W-1:0];
   assign mem_wdata = l1_fire ? {1'b1, next_free_ff[PPN_W-1:0]} : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mirror[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         mirror_rd_ff <= mirror[req_data.virt_addr[31:22]];
      end else if (l1_fire) begin
         mirror_rd_ff <= {1'b1, next_free_ff[PPN_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_page_ff <= '0;
         pool_end_ff  <= '0;
         next_free_ff <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROOT_PAGE:  root_page_ff <= csr_data[PPN_W-1:0];
               CSR_POOL_START: next_free_ff <= {1'b0, csr_data[PPN_W-1:0]};
               CSR_POOL_END:   pool_end_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         if (l1_fire) begin
            next_free_ff <= next_free_ff + 21'd1;
         end
         if (uop.op == OP_CLEAR && clr_busy) begin
            clr_cnt_ff <= clr_cnt_ff + 11'd1;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/sv32_page_mapper.sv
// Sv32 page mapper top level: sequencer plus datapath, and the block's assertions.
// Depends on spm_pkg, spm_sequencer and spm_datapath.
//
// The block installs Sv32 two-level mappings one request beat at a time. Each
// request carries a page-aligned virtual address, a page-aligned physical
// address and PTE flags; the response channel returns the page-table-entry
// writes that the caller must perform, in order. When the root entry for the
// request's top ten virtual bits has not been set yet, the block first takes a
// page from its bump pointer and returns a level-1 entry write (kind new
// table, last low); the caller must zero that page before using it. The leaf
// write with the valid bit forced on always follows as the last beat. An
// unaligned address or an exhausted page pool returns a single error beat and
// leaves all state untouched. After reset the block sweeps its 1024-entry root
// mirror clean, one entry per cycle, stalling requests until the sweep ends;
// configuration writes are accepted at any time, including during the sweep,
// and csr_ready is always high. The flow is set by the microcode program and the
// registered read of the root mirror: a request is accepted in one step, checked
// against the mirror in the next, and each response beat takes one further step.
// An emit step is held in place while the response side stalls, and no new
// request is taken until the last beat of the previous one has been emitted.
module sv32_page_mapper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  spm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output spm_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [spm_pkg::CSR_DATA_W-1:0] csr_data
);
   import spm_pkg::*;

   uop_type     uop;
   dp_stat_type stat;

   // The sequencer walks the control program and tells the datapath what to do.
   spm_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .uop       (uop)
   );

   // The datapath holds the mirror, the pointer and the response register.
   spm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .uop       (uop),
      .stat      (stat),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // No request may be taken while the root mirror is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !stat.clr_busy)
      else $error("request accepted during the mirror clearing sweep");

   // Only a new-table write is ever followed by another beat of the same request.
   a_not_last_is_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.kind == KIND_NEW_TABLE))
      else $error("non-final response beat that is not a level-1 entry write");

   // An error beat is final, carries no write and names a cause.
   a_error_beat_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_ERROR) |->
         (rsp_data.last && rsp_data.write_addr == 32'd0 &&
          rsp_data.status != STATUS_OK))
      else $error("malformed error response beat");

   // The block holds off requests while a response beat is pending in its work.
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken in the cycle right after an accepted request");

endmodule
